FILE: rtl/hds_pkg.sv
// Shared types and constants for the heat diffusion stencil pass unit.
`timescale 1ns / 1ps

package hds_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WID_W  = 11;
  localparam int HGT_W  = 13;
  localparam int PIX_W  = 16;
  localparam int STEP_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int LAP_W       = PIX_W + 3;
  localparam int PROD_W      = STEP_W + LAP_W;
  localparam int FRAC_SHIFT  = 14;
  localparam int ROUND_BIAS  = 2 ** (FRAC_SHIFT - 1);
  localparam int Q_W         = PROD_W - FRAC_SHIFT;
  localparam int SUM_W       = Q_W + 1;
  localparam int PIX_MAX     = 2 ** (PIX_W - 1) - 1;
  localparam int PIX_MIN     = -(2 ** (PIX_W - 1));

  localparam int WIDTH_RESET  = 1024;
  localparam int HEIGHT_RESET = 4096;
  localparam int STEP_RESET   = 1638;

  localparam int MQ_DEPTH = 4;
  localparam int MQ_PTR_W = $clog2(MQ_DEPTH);
  localparam int MQ_CNT_W = $clog2(MQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_TIME_STEP    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [PIX_W-1:0] x;
    logic                    c0;
    logic                    c1;
    logic                    r1;
    logic                    lastc;
    logic [2:0]              need;
  } front_ctl_t;

  typedef struct packed {
    front_ctl_t              ctl;
    logic signed [PIX_W-1:0] pc;
    logic signed [PIX_W-1:0] pn;
    logic signed [PIX_W-1:0] old;
  } mid_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [PIX_W-1:0] pix;
    logic                    fe;
  } out_item_t;

endpackage

FILE: rtl/hds_front.sv
// Front part: configuration registers, raster counters, line stores and item classification.
`timescale 1ns / 1ps

module hds_front import hds_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  input  logic signed [PIX_W-1:0]      in_pixel_in,
  output logic                         in_full,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic [MQ_CNT_W-1:0]          mq_count,
  output logic                         mq_push,
  output mid_item_t                    mq_item,
  output logic signed [STEP_W-1:0]     time_step
);

  logic [WID_W-1:0]         image_width_r;
  logic [HGT_W-1:0]         image_height_r;
  logic signed [STEP_W-1:0] time_step_r;
  logic [COL_W-1:0]         col_r;
  logic [ROW_W-1:0]         row_r;
  logic                     v_r;
  front_ctl_t               ctl_r;
  logic signed [PIX_W-1:0]  pc_rd_r;
  logic signed [PIX_W-1:0]  pn_rd_r;
  logic signed [PIX_W-1:0]  old_rd_r;

  logic signed [PIX_W-1:0] prev_mem  [MAX_WIDTH];
  logic signed [PIX_W-1:0] older_mem [MAX_WIDTH];

  logic [WID_W-1:0]  w_eff;
  logic [WID_W-1:0]  wm1;
  logic [HGT_W-1:0]  h_eff;
  logic [HGT_W-1:0]  hm1;
  logic [COL_W-1:0]  c;
  logic [ROW_W-1:0]  r;
  logic [COL_W-1:0]  addr_n;
  logic              lastc;
  logic              lastr;
  logic              accept;
  logic [MQ_CNT_W:0] occ;
  front_ctl_t        ctl;

  always_comb begin
    if (image_width_r < WID_W'(2)) begin
      w_eff = WID_W'(2);
    end else if (image_width_r > WID_W'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width_r;
    end
    if (image_height_r < HGT_W'(2)) begin
      h_eff = HGT_W'(2);
    end else if (image_height_r > HGT_W'(MAX_HEIGHT)) begin
      h_eff = HGT_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height_r;
    end
    wm1 = w_eff - WID_W'(1);
    hm1 = h_eff - HGT_W'(1);
    c   = (WID_W'(col_r) > wm1) ? wm1[COL_W-1:0] : col_r;
    r   = (HGT_W'(row_r) > hm1) ? hm1[ROW_W-1:0] : row_r;
    lastc  = (WID_W'(c) == wm1);
    lastr  = (HGT_W'(r) == hm1);
    addr_n = c + COL_W'(1);

    occ     = {1'b0, mq_count} + {{MQ_CNT_W{1'b0}}, v_r};
    in_full = (occ >= (MQ_CNT_W + 1)'(MQ_DEPTH));
    accept  = in_push && !in_full;

    ctl.row   = r;
    ctl.col   = c;
    ctl.x     = in_pixel_in;
    ctl.c0    = (c == COL_W'(0));
    ctl.c1    = (c == COL_W'(1));
    ctl.r1    = (r == ROW_W'(1));
    ctl.lastc = lastc;
    ctl.need  = {lastr && lastc, lastr && (c != COL_W'(0)), r != ROW_W'(0)};
  end

  // The previous row store is read before it is overwritten at the same column.
  always_ff @(posedge clk) begin
    if (accept) begin
      pc_rd_r       <= prev_mem[c];
      pn_rd_r       <= prev_mem[addr_n];
      old_rd_r      <= older_mem[c];
      prev_mem[c]   <= in_pixel_in;
      ctl_r         <= ctl;
    end
    if (v_r) begin
      older_mem[ctl_r.col] <= pc_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r            <= 1'b0;
      col_r          <= '0;
      row_r          <= '0;
      image_width_r  <= WID_W'(WIDTH_RESET);
      image_height_r <= HGT_W'(HEIGHT_RESET);
      time_step_r    <= STEP_W'(STEP_RESET);
    end else begin
      v_r <= accept;
      if (accept) begin
        if (lastc) begin
          col_r <= '0;
          row_r <= lastr ? '0 : r + ROW_W'(1);
        end else begin
          col_r <= c + COL_W'(1);
          row_r <= r;
        end
      end
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[WID_W-1:0];
          REG_IMAGE_HEIGHT: image_height_r <= cfg_data[HGT_W-1:0];
          REG_TIME_STEP:    time_step_r    <= cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign cfg_ready = 1'b1;
  assign mq_push   = v_r;
  assign mq_item   = '{ctl: ctl_r, pc: pc_rd_r, pn: pn_rd_r, old: old_rd_r};
  assign time_step = time_step_r;

endmodule

FILE: rtl/hds_queue.sv
// Short queue of classified items between the front and back parts.
`timescale 1ns / 1ps

module hds_queue import hds_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mid_item_t           push_item,
  input  logic                pop,
  output mid_item_t           head,
  output logic                empty,
  output logic [MQ_CNT_W-1:0] count
);

  mid_item_t           mem_r [MQ_DEPTH];
  logic [MQ_PTR_W-1:0] wr_ptr_r;
  logic [MQ_PTR_W-1:0] rd_ptr_r;
  logic [MQ_CNT_W-1:0] count_r;
  logic                do_pop;

  assign empty  = (count_r == '0);
  assign do_pop = pop && !empty;
  assign head   = mem_r[rd_ptr_r];
  assign count  = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + MQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + MQ_PTR_W'(1);
      end
      count_r <= count_r + MQ_CNT_W'(push) - MQ_CNT_W'(do_pop);
    end
  end

endmodule

FILE: rtl/hds_back.sv
// Back part: result sequencing, stencil arithmetic pipeline and result queue.
`timescale 1ns / 1ps

module hds_back import hds_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     mq_empty,
  input  mid_item_t                mq_head,
  output logic                     mq_pop,
  input  logic signed [STEP_W-1:0] time_step,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [ROW_W-1:0]         out_row,
  output logic [COL_W-1:0]         out_col,
  output logic signed [PIX_W-1:0]  out_pixel_out,
  output logic                     out_frame_end
);

  logic signed [PIX_W-1:0]  w0_r;
  logic signed [PIX_W-1:0]  w1_r;
  logic signed [PIX_W-1:0]  w2_r;
  logic [2:0]               done_r;
  logic                     s1_v_r;
  logic signed [LAP_W-1:0]  s1_lap_r;
  out_item_t                s1_tag_r;
  logic                     s2_v_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  out_item_t                s2_tag_r;

  out_item_t           oq_mem_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wr_r;
  logic [OQ_PTR_W-1:0] oq_rd_r;
  logic [OQ_CNT_W-1:0] oq_count_r;

  mid_item_t               it;
  logic [2:0]              pending;
  logic [2:0]              sel;
  logic [OQ_CNT_W:0]       occ;
  logic                    issue;
  logic                    retire;
  logic signed [PIX_W-1:0] op_c;
  logic signed [PIX_W-1:0] op_l;
  logic signed [PIX_W-1:0] op_r;
  logic signed [PIX_W-1:0] op_u;
  logic signed [PIX_W-1:0] op_d;
  out_item_t               tag;
  logic signed [LAP_W-1:0] lap;
  logic signed [PROD_W-1:0] rnd;
  logic signed [Q_W-1:0]   q;
  logic signed [SUM_W-1:0] y;
  out_item_t               res;
  logic                    oq_pop;

  always_comb begin
    it      = mq_head;
    pending = it.ctl.need & ~done_r;
    sel     = pending & (~pending + 3'd1);
    occ     = {1'b0, oq_count_r} + {{OQ_CNT_W{1'b0}}, s1_v_r}
              + {{OQ_CNT_W{1'b0}}, s2_v_r};
    issue   = !mq_empty && (pending != 3'b000) && (occ < (OQ_CNT_W + 1)'(OQ_DEPTH));
    retire  = !mq_empty && ((pending == 3'b000) || (issue && (pending == sel)));
    mq_pop  = retire;

    unique case (sel)
      3'b001: begin
        op_c = it.pc;
        op_l = it.ctl.c0 ? it.pn : w2_r;
        op_r = it.ctl.lastc ? w2_r : it.pn;
        op_u = it.ctl.r1 ? it.ctl.x : it.old;
        op_d = it.ctl.x;
        tag  = '{row: it.ctl.row - ROW_W'(1), col: it.ctl.col, pix: it.pc, fe: 1'b0};
      end
      3'b010: begin
        op_c = w1_r;
        op_l = it.ctl.c1 ? it.ctl.x : w0_r;
        op_r = it.ctl.x;
        op_u = w2_r;
        op_d = w2_r;
        tag  = '{row: it.ctl.row, col: it.ctl.col - COL_W'(1), pix: w1_r, fe: 1'b0};
      end
      3'b100: begin
        op_c = it.ctl.x;
        op_l = w1_r;
        op_r = w1_r;
        op_u = it.pc;
        op_d = it.pc;
        tag  = '{row: it.ctl.row, col: it.ctl.col, pix: it.ctl.x, fe: 1'b1};
      end
      default: begin
        op_c = '0;
        op_l = '0;
        op_r = '0;
        op_u = '0;
        op_d = '0;
        tag  = '0;
      end
    endcase

    lap = LAP_W'(op_l) + LAP_W'(op_r) + LAP_W'(op_u) + LAP_W'(op_d)
          - (LAP_W'(op_c) <<< 2);

    // Round half up, then floor to the pixel fraction.
    rnd = s2_prod_r + PROD_W'(ROUND_BIAS);
    q   = rnd[PROD_W-1:FRAC_SHIFT];
    y   = SUM_W'(s2_tag_r.pix) + SUM_W'(q);
    res = s2_tag_r;
    if (y > SUM_W'(PIX_MAX)) begin
      res.pix = PIX_W'(PIX_MAX);
    end else if (y < SUM_W'(PIX_MIN)) begin
      res.pix = PIX_W'(PIX_MIN);
    end else begin
      res.pix = y[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    s1_lap_r  <= lap;
    s1_tag_r  <= tag;
    s2_prod_r <= time_step * s1_lap_r;
    s2_tag_r  <= s1_tag_r;
    if (s2_v_r) begin
      oq_mem_r[oq_wr_r] <= res;
    end
  end

  assign out_empty = (oq_count_r == '0);
  assign oq_pop    = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w0_r       <= '0;
      w1_r       <= '0;
      w2_r       <= '0;
      done_r     <= '0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      oq_wr_r    <= '0;
      oq_rd_r    <= '0;
      oq_count_r <= '0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      if (retire) begin
        done_r <= '0;
        w0_r   <= w1_r;
        w1_r   <= it.ctl.x;
        w2_r   <= it.pc;
      end else if (issue) begin
        done_r <= done_r | sel;
      end
      if (s2_v_r) begin
        oq_wr_r <= oq_wr_r + OQ_PTR_W'(1);
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + OQ_PTR_W'(1);
      end
      oq_count_r <= oq_count_r + OQ_CNT_W'(s2_v_r) - OQ_CNT_W'(oq_pop);
    end
  end

  assign out_row       = oq_mem_r[oq_rd_r].row;
  assign out_col       = oq_mem_r[oq_rd_r].col;
  assign out_pixel_out = oq_mem_r[oq_rd_r].pix;
  assign out_frame_end = oq_mem_r[oq_rd_r].fe;

endmodule

FILE: rtl/heat_diffusion_stencil_pass_unit.sv
// Top level of the heat diffusion stencil pass unit.
`timescale 1ns / 1ps

// Pixels enter in row-major order as queue beats: a beat is taken when in_push is high
// and in_full is low. Results leave the same way: the oldest result is on out_row,
// out_col, out_pixel_out and out_frame_end while out_empty is low, and a beat is taken
// when out_pop is high. The cfg channel writes image_width, image_height and time_step
// by index; it is always ready and should be used only while the block is idle.
// Each result is the pixel plus time_step times the five-point Laplacian, with mirrored
// borders, rounded and saturated. Row r-1 comes out while row r streams in, and the
// last row comes out one pixel behind the input, plus the last pixel on the final beat.
// The front takes one pixel per cycle while in_full is low; the back issues one result
// per cycle through a shared multiply pipeline while the result queue has room, and on
// the last row a pixel needs up to two results and the final pixel three. After reset
// the counters, window and queues are clear and the registers hold their reset values;
// the line stores fill during the first two rows. When the receiver stops popping, the
// result queue and the item queue fill and in_full rises.
module heat_diffusion_stencil_pass_unit import hds_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic signed [PIX_W-1:0]     in_pixel_in,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [ROW_W-1:0]            out_row,
  output logic [COL_W-1:0]            out_col,
  output logic signed [PIX_W-1:0]     out_pixel_out,
  output logic                        out_frame_end,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  logic                     mq_push;
  mid_item_t                mq_item;
  logic                     mq_pop;
  mid_item_t                mq_head;
  logic                     mq_empty;
  logic [MQ_CNT_W-1:0]      mq_count;
  logic signed [STEP_W-1:0] time_step;

  hds_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_pixel_in (in_pixel_in),
    .in_full     (in_full),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mq_count    (mq_count),
    .mq_push     (mq_push),
    .mq_item     (mq_item),
    .time_step   (time_step)
  );

  hds_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mq_push),
    .push_item (mq_item),
    .pop       (mq_pop),
    .head      (mq_head),
    .empty     (mq_empty),
    .count     (mq_count)
  );

  hds_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .mq_empty      (mq_empty),
    .mq_head       (mq_head),
    .mq_pop        (mq_pop),
    .time_step     (time_step),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_pixel_out (out_pixel_out),
    .out_frame_end (out_frame_end)
  );

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the heat diffusion stencil pass unit.
`timescale 1ns / 1ps

module testbench;
  import hds_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_CYCLES  = 400;
  localparam int STALL_COL     = 3;
  localparam int RANDOM_ITEMS  = 25;

  typedef enum int {PIX_FULL, PIX_MILD, PIX_EXTREME, PIX_CORNER} pix_mode_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_push = 1'b0;
  logic                    in_full;
  logic signed [PIX_W-1:0] in_pixel_in = '0;
  logic                    out_empty;
  logic                    out_pop = 1'b0;
  logic [ROW_W-1:0]        out_row;
  logic [COL_W-1:0]        out_col;
  logic signed [PIX_W-1:0] out_pixel_out;
  logic                    out_frame_end;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  cfg_reg_t                cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  // Mirror of the block: line stores, window, raster position and registers.
  logic signed [PIX_W-1:0] older_line [MAX_WIDTH];
  logic signed [PIX_W-1:0] recent_line [MAX_WIDTH];
  logic signed [PIX_W-1:0] row_window [3];
  int unsigned             row_pos = 0;
  int unsigned             col_pos = 0;
  logic [WID_W-1:0]        width_reg = WID_W'(WIDTH_RESET);
  logic [HGT_W-1:0]        height_reg = HGT_W'(HEIGHT_RESET);
  logic signed [STEP_W-1:0] step_reg = STEP_W'(STEP_RESET);

  out_item_t               diffused_q[$];
  logic signed [PIX_W-1:0] raster_q[$];

  int  beats_planned = 0;
  int  beats_in = 0;
  int  results_checked = 0;
  int  error_count = 0;
  int  phases_run = 0;
  int  reg_writes = 0;
  int  cycle_count = 0;
  int  hold_left = 0;
  bit  gaps_on = 1'b1;
  bit  stall_done = 1'b0;

  heat_diffusion_stencil_pass_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_pixel_in   (in_pixel_in),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_pixel_out (out_pixel_out),
    .out_frame_end (out_frame_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(int unsigned val, int unsigned hi);
    if (val < 2) return 2;
    if (val > hi) return hi;
    return val;
  endfunction

  // Center plus step times the five-point Laplacian, rounded half up, saturated.
  function automatic logic signed [PIX_W-1:0] heat_update(int center, int west, int east,
                                                          int north, int south);
    longint lap;
    longint prod;
    longint sum;
    lap = longint'(west) + east + north + south - 4 * longint'(center);
    prod = longint'(step_reg) * lap + ROUND_BIAS;
    sum = center + (prod >>> FRAC_SHIFT);
    if (sum > PIX_MAX) sum = PIX_MAX;
    if (sum < PIX_MIN) sum = PIX_MIN;
    return PIX_W'(sum);
  endfunction

  task automatic expect_pixel(int unsigned row, int unsigned col,
                              logic signed [PIX_W-1:0] pix, logic fe);
    out_item_t item;
    item.row = ROW_W'(row);
    item.col = COL_W'(col);
    item.pix = pix;
    item.fe = fe;
    diffused_q.push_back(item);
  endtask

  task automatic diffuse_pixel(logic signed [PIX_W-1:0] x);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    bit lastc;
    bit lastr;
    logic signed [PIX_W-1:0] pc;
    logic signed [PIX_W-1:0] pl;
    logic signed [PIX_W-1:0] pr;
    logic signed [PIX_W-1:0] up;
    logic signed [PIX_W-1:0] left;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    c = (col_pos > w - 1) ? w - 1 : col_pos;
    r = (row_pos > h - 1) ? h - 1 : row_pos;
    lastc = (c == w - 1);
    lastr = (r == h - 1);
    pc = recent_line[c];
    pl = (c == 0) ? recent_line[1] : row_window[2];
    pr = lastc ? row_window[2] : recent_line[c + 1];
    if (r >= 1) begin
      up = (r == 1) ? x : older_line[c];
      expect_pixel(r - 1, c, heat_update(pc, pl, pr, up, x), 1'b0);
    end
    if (lastr && c >= 1) begin
      left = (c == 1) ? x : row_window[0];
      expect_pixel(r, c - 1,
                   heat_update(row_window[1], left, x, row_window[2], row_window[2]), 1'b0);
    end
    if (lastr && lastc) begin
      expect_pixel(r, c, heat_update(x, row_window[1], row_window[1], pc, pc), 1'b1);
    end
    older_line[c] = pc;
    recent_line[c] = x;
    row_window[0] = row_window[1];
    row_window[1] = x;
    row_window[2] = pc;
    if (lastc) begin
      col_pos = 0;
      row_pos = lastr ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  function automatic logic signed [PIX_W-1:0] pick_pixel(pix_mode_t mode);
    case (mode)
      PIX_MILD: return PIX_W'(int'($urandom_range(4000)) - 2000);
      PIX_EXTREME: return $urandom_range(1) ? PIX_W'(PIX_MAX) : PIX_W'(PIX_MIN);
      PIX_CORNER: begin
        case ($urandom_range(4))
          0: return PIX_W'(PIX_MAX);
          1: return PIX_W'(PIX_MIN);
          2: return '0;
          3: return '1;
          default: return PIX_W'(1);
        endcase
      end
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic wait_idle(int settle);
    do @(posedge clk); while (beats_in != beats_planned || diffused_q.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_config(int unsigned width, int unsigned height, int step);
    cfg_reg_t              regs [3];
    logic [CFG_DATA_W-1:0] vals [3];
    regs = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_TIME_STEP};
    vals = '{CFG_DATA_W'(width & ((1 << WID_W) - 1)),
             CFG_DATA_W'(height & ((1 << HGT_W) - 1)),
             CFG_DATA_W'(step)};
    cfg_valid <= 1'b1;
    foreach (regs[i]) begin
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (regs[i])
        REG_IMAGE_WIDTH: width_reg = WID_W'(vals[i]);
        REG_IMAGE_HEIGHT: height_reg = HGT_W'(vals[i]);
        default: step_reg = vals[i];
      endcase
      reg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  // A cut of zero queues the whole frame; otherwise only that many pixels.
  task automatic run_frame(int unsigned width, int unsigned height, int step,
                           pix_mode_t mode, int cut);
    int count;
    wait_idle(SETTLE_CYCLES);
    write_config(width, height, step);
    count = (cut != 0) ? cut : clamp_dim(width, MAX_WIDTH) * clamp_dim(height, MAX_HEIGHT);
    @(negedge clk);
    repeat (count) raster_q.push_back(pick_pixel(mode));
    beats_planned += count;
    phases_run++;
  endtask

  always @(posedge clk) begin : pixel_driver
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        diffuse_pixel(in_pixel_in);
        beats_in++;
      end
      if (!(in_push && in_full)) begin
        if (raster_q.size() != 0 && !(gaps_on && $urandom_range(99) < 20)) begin
          in_push <= 1'b1;
          in_pixel_in <= raster_q.pop_front();
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (diffused_q.size() == 0) begin
          $error("Result beat with nothing pending: row %0d col %0d", out_row, out_col);
          error_count++;
        end else begin
          want = diffused_q.pop_front();
          results_checked++;
          if (out_row !== want.row) begin
            $error("out_row: expected %0d, got %0d", want.row, out_row);
            error_count++;
          end
          if (out_col !== want.col) begin
            $error("out_col: expected %0d, got %0d", want.col, out_col);
            error_count++;
          end
          if (out_pixel_out !== want.pix) begin
            $error("out_pixel_out: expected %0d, got %0d", want.pix, out_pixel_out);
            error_count++;
          end
          if (out_frame_end !== want.fe) begin
            $error("out_frame_end: expected %0d, got %0d", want.fe, out_frame_end);
            error_count++;
          end
        end
      end
      if (hold_left != 0) begin
        out_pop <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!stall_done && !out_empty && out_col == STALL_COL) begin
        out_pop <= 1'b0;
        hold_left <= STALL_CYCLES;
        stall_done <= 1'b1;
      end else begin
        out_pop <= !(gaps_on && $urandom_range(99) < 20);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned w;
    int unsigned h;
    int step;
    int random_items;
    pix_mode_t mode;
    random_items = 0;
    foreach (older_line[i]) begin
      older_line[i] = '0;
      recent_line[i] = '0;
    end
    foreach (row_window[i]) row_window[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    run_frame(2, 2, 32767, PIX_EXTREME, 0);
    run_frame(3, 3, -32768, PIX_CORNER, 0);
    run_frame(1, 0, 0, PIX_FULL, 0);
    run_frame(0, 1, STEP_RESET, PIX_MILD, 0);

    // A longer frame with no random gaps; the output side stalls partway through.
    gaps_on = 1'b0;
    run_frame(20, 2, int'($urandom_range(65535)) - 32768, PIX_MILD, 0);
    wait_idle(SETTLE_CYCLES);
    gaps_on = 1'b1;

    // Shrink the frame while the counters sit past the new bounds.
    step = int'($urandom_range(8192));
    run_frame(6, 5, step, PIX_FULL, 23);
    run_frame(4, 3, step, PIX_FULL, 1);

    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0: w = $urandom_range(1);
        1: w = $urandom_range(8, 12);
        default: w = $urandom_range(2, 5);
      endcase
      h = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 3);
      case ($urandom_range(3))
        0: step = int'($urandom_range(65535)) - 32768;
        1: step = int'($urandom_range(4096));
        2: step = -int'($urandom_range(4096));
        default: step = $urandom_range(1) ? 32767 : -32768;
      endcase
      mode = pix_mode_t'($urandom_range(2));
      run_frame(w, h, step, mode, 0);
      random_items += clamp_dim(w, MAX_WIDTH) * clamp_dim(h, MAX_HEIGHT);
    end

    wait_idle(SETTLE_CYCLES * 2);
    $display("Streamed %0d pixels over %0d phases; %0d results checked, %0d register writes.",
             beats_in, phases_run, results_checked, reg_writes);
    $display("Frames from 2x2 up to 20 wide, undersized settings clamped, a mid-frame %s",
             "resize and a long output stall that filled the block.");
    if (error_count == 0 && diffused_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
